// File: rtl/sads_pkg.sv
// Package: sizes, operation and status codes, controller/datapath link types.
`timescale 1ns / 1ps
package sads_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned FILL_W     = $clog2(DEPTH + 1);
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the request item
    logic exec;  // update pointers, write or read the store
  } sads_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exec_done;  // result fields and read data are settled
  } sads_stat_t;

endpackage

// File: rtl/sads_if.sv
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface sads_req_if;
  import sads_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic                     side;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, op, side, push_value, input ready);
  modport sink   (input valid, op, side, push_value, output ready);
endinterface

interface sads_rsp_if;
  import sads_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;
  logic                     first_empty;
  logic                     second_empty;
  logic [COUNT_W-1:0]       first_count;
  logic [COUNT_W-1:0]       second_count;

  modport source (output valid, read_value, status, first_empty, second_empty,
                  first_count, second_count, input ready);
  modport sink   (input valid, read_value, status, first_empty, second_empty,
                  first_count, second_count, output ready);
endinterface

// File: rtl/sads_ctrl.sv
// Controller: sequences accept, execute and response of one item.
`timescale 1ns / 1ps
module sads_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sads_pkg::sads_cmd_t  cmd_o,
  input  sads_pkg::sads_stat_t stat_i
);
  import sads_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: if (stat_i.exec_done) state_d = S_RESP;
      S_RESP: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC) && !stat_i.exec_done;
endmodule

// File: rtl/sads_dpath.sv
// Datapath: shared word store, the two fill pointers and result fields.
`timescale 1ns / 1ps
module sads_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sads_pkg::sads_cmd_t             cmd_i,
  output sads_pkg::sads_stat_t            stat_o,
  input  logic [sads_pkg::OP_W-1:0]       op_i,
  input  logic                            side_i,
  input  logic signed [sads_pkg::DATA_W-1:0] push_value_i,
  output logic signed [sads_pkg::DATA_W-1:0] read_value_o,
  output logic [sads_pkg::STATUS_W-1:0]   status_o,
  output logic                            first_empty_o,
  output logic                            second_empty_o,
  output logic [sads_pkg::COUNT_W-1:0]    first_count_o,
  output logic [sads_pkg::COUNT_W-1:0]    second_count_o
);
  import sads_pkg::*;

  logic [WORD_WIDTH-1:0] mem_q [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_q;

  logic [OP_W-1:0]       op_q;
  logic                  side_q;
  logic [WORD_WIDTH-1:0] wval_q;

  logic [FILL_W-1:0]   lower_q, lower_d, upper_q, upper_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                rd_ok_q, rd_ok_d;
  logic                done_q;

  logic [FILL_W:0]     total;
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   wr_idx, rd_idx;
  logic [ADDR_W-1:0]   addr;
  logic                we, re;

  // Capture the request payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      side_q <= side_i;
      wval_q <= push_value_i[WORD_WIDTH-1:0];
    end
  end

  always_comb begin
    total    = {1'b0, lower_q} + {1'b0, upper_q};
    fill     = side_q ? upper_q : lower_q;
    wr_idx   = side_q ? FILL_W'(DEPTH - 1) - upper_q : lower_q;
    rd_idx   = side_q ? FILL_W'(DEPTH) - upper_q : lower_q - FILL_W'(1);
    lower_d  = lower_q;
    upper_d  = upper_q;
    status_d = ST_OK;
    rd_ok_d  = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    addr     = rd_idx[ADDR_W-1:0];
    case (op_q)
      OP_PUSH: begin
        addr = wr_idx[ADDR_W-1:0];
        if (total >= (FILL_W + 1)'(DEPTH)) begin
          status_d = ST_OVER;
        end else begin
          we = 1'b1;
          if (side_q) upper_d = upper_q + FILL_W'(1);
          else        lower_d = lower_q + FILL_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (fill == '0) begin
          status_d = ST_UNDER;
        end else begin
          re      = 1'b1;
          rd_ok_d = 1'b1;
          if (op_q == OP_POP) begin
            if (side_q) upper_d = upper_q - FILL_W'(1);
            else        lower_d = lower_q - FILL_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Single-port store with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) mem_q[addr] <= wval_q;
    if (cmd_i.exec && re) rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= '0;
      upper_q  <= '0;
      status_q <= ST_OK;
      rd_ok_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        lower_q  <= lower_d;
        upper_q  <= upper_d;
        status_q <= status_d;
        rd_ok_q  <= rd_ok_d;
      end
    end
  end

  assign stat_o.exec_done = done_q;
  assign read_value_o     = rd_ok_q ? DATA_W'($signed(rdata_q)) : '0;
  assign status_o         = status_q;
  assign first_empty_o    = (lower_q == '0);
  assign second_empty_o   = (upper_q == '0);
  assign first_count_o    = COUNT_W'(lower_q);
  assign second_count_o   = COUNT_W'(upper_q);
endmodule

// File: rtl/shared_array_dual_stack_unit.sv
// Top level: two stacks sharing one word store, controller plus datapath.
`timescale 1ns / 1ps
// Two LIFO stacks share one store of 1024 words: stack one (side 0) grows up
// from entry 0, stack two (side 1) grows down from the last entry. Each request
// item is a push, pop or peek on one side; the response item carries the read
// word (zero for pushes and refused requests), a status (ok, overflow when
// both stacks together fill the store, underflow on an empty side) and both
// empty flags and fill counts after the request. Unused op codes return ok and
// change nothing. One item is in flight at a time: it is accepted, executed
// against the single-port store in the next cycle, the controller then waits
// for the datapath's registered done flag, and the response is shown after
// that. The store needs no clearing after reset: only entries pushed since
// reset are ever read.
module shared_array_dual_stack_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sads_req_if.sink   req_i,
  sads_rsp_if.source rsp_o
);
  import sads_pkg::*;

  sads_cmd_t  cmd;
  sads_stat_t stat;

  // Sequence the handshakes and the execute step.
  sads_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Hold the store, the fill pointers and the response fields.
  sads_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (req_i.op),
    .side_i         (req_i.side),
    .push_value_i   (req_i.push_value),
    .read_value_o   (rsp_o.read_value),
    .status_o       (rsp_o.status),
    .first_empty_o  (rsp_o.first_empty),
    .second_empty_o (rsp_o.second_empty),
    .first_count_o  (rsp_o.first_count),
    .second_count_o (rsp_o.second_count)
  );

  // Never take a new item while a response is pending.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.valid && req_i.ready))
    else $error("request accepted while response pending");

  // An accepted item shows its response after the controller's execute state.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> ##2 rsp_o.valid)
    else $error("response not presented on time");

  // The two stacks together never exceed the store.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ({1'b0, rsp_o.first_count} + {1'b0, rsp_o.second_count})
                    <= (COUNT_W + 1)'(DEPTH))
    else $error("fill counts exceed store depth");

  // A refused request returns zero data.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == ST_OVER || rsp_o.status == ST_UNDER))
      |-> (rsp_o.read_value == '0))
    else $error("refused request returned data");
endmodule

// File: verif/sads_tb_pkg.sv
// Shadow model of the two stacks plus the queue of results it predicts.
`timescale 1ns / 1ps
package sads_tb_pkg;
  import sads_pkg::*;

  // op code that the block accepts and ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0]   read_value;
    logic [STATUS_W-1:0] status;
    logic                first_empty;
    logic                second_empty;
    logic [COUNT_W-1:0]  first_count;
    logic [COUNT_W-1:0]  second_count;
  } stack_result_t;

  class dual_stack_scoreboard;
    logic [DATA_W-1:0] shadow_words [DEPTH];
    int unsigned       bottom_depth;
    int unsigned       top_depth;
    stack_result_t     awaited_results [$];
    int unsigned       errors;

    function new();
      bottom_depth = 0;
      top_depth    = 0;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // Apply one accepted request to the shadow stacks and queue its result.
    function void note_request(logic [OP_W-1:0] op, logic side, logic [DATA_W-1:0] value);
      stack_result_t res;
      int unsigned   fill;
      res        = '0;
      res.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (bottom_depth + top_depth >= DEPTH) begin
            res.status = ST_OVER;
          end else if (!side) begin
            shadow_words[bottom_depth] = value;
            bottom_depth++;
          end else begin
            shadow_words[DEPTH - 1 - top_depth] = value;
            top_depth++;
          end
        end
        OP_POP, OP_PEEK: begin
          fill = side ? top_depth : bottom_depth;
          if (fill == 0) begin
            res.status = ST_UNDER;
          end else begin
            res.read_value = side ? shadow_words[DEPTH - fill] : shadow_words[fill - 1];
            if (op == OP_POP) begin
              if (side) top_depth--;
              else bottom_depth--;
            end
          end
        end
        default: ;
      endcase
      res.first_empty  = (bottom_depth == 0);
      res.second_empty = (top_depth == 0);
      res.first_count  = COUNT_W'(bottom_depth);
      res.second_count = COUNT_W'(top_depth);
      awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Match one accepted response against the oldest prediction.
    function void check_response(stack_result_t seen);
      stack_result_t want;
      if (awaited_results.size() == 0) begin
        $error("response item with no request outstanding");
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("read_value", want.read_value, seen.read_value);
      compare_field("status", DATA_W'(want.status), DATA_W'(seen.status));
      compare_field("first_empty", DATA_W'(want.first_empty), DATA_W'(seen.first_empty));
      compare_field("second_empty", DATA_W'(want.second_empty), DATA_W'(seen.second_empty));
      compare_field("first_count", DATA_W'(want.first_count), DATA_W'(seen.first_count));
      compare_field("second_count", DATA_W'(want.second_count), DATA_W'(seen.second_count));
    endfunction
  endclass

endpackage

// File: verif/tb_shared_array_dual_stack_unit.sv
// Testbench top: drives stack requests, randomizes handshakes, checks every response item.
`timescale 1ns / 1ps
module tb_shared_array_dual_stack_unit;
  import sads_pkg::*;
  import sads_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1640;
  localparam int unsigned PHASE_ITEMS  = 410;
  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned FULL_DWELL   = 24;
  // worst case: every item waits out the longest sender gap plus a long
  // receiver stall, then the hold-off; taken several times over
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        rsp_hold;
  logic        pressure_req;
  idle_mode_e  idle_mode;
  int unsigned cycle_count = 0;

  // random-stimulus steering: fill toward a full store, then drain
  logic        filling;
  int unsigned full_items;
  int unsigned side_skew;

  dual_stack_scoreboard book;

  sads_req_if req_if ();
  sads_rsp_if rsp_if ();

  shared_array_dual_stack_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      IDLE_SENDER: return 83;
      IDLE_BOTH:   return 33;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 83;
      IDLE_BOTH:     return 33;
      default:       return 0;
    endcase
  endfunction

  // Check each accepted response item, then pick ready for the next cycle.
  // The long hold-off overrides the random choice and keeps ready low.
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      book.check_response(stack_result_t'{
        read_value:   rsp_if.read_value,
        status:       rsp_if.status,
        first_empty:  rsp_if.first_empty,
        second_empty: rsp_if.second_empty,
        first_count:  rsp_if.first_count,
        second_count: rsp_if.second_count
      });
    end
    rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= receiver_stall_pct());
  end

  // Hold the response side off for a long stretch once asked, so the block
  // fills up and has to stall its request side while the sender keeps offering.
  initial begin
    wait (pressure_req);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  // Offer one request item and wait for its acceptance. Valid stays high on
  // return so that a back-to-back item never drops it within one step.
  task automatic offer_request(input logic [OP_W-1:0] op, input logic side,
                               input logic [DATA_W-1:0] value);
    int unsigned pct;
    int unsigned gap;
    pct = sender_idle_pct();
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.side       <= side;
    req_if.push_value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    book.note_request(op, side, value);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Build one random request. While filling, push mostly to one skewed side
  // until the store is full; dwell there to hit overflow, then drain until
  // the stacks are nearly empty so that underflow shows up as well.
  task automatic random_request();
    int unsigned       held;
    int unsigned       roll;
    logic [OP_W-1:0]   op;
    logic              side;
    held = book.bottom_depth + book.top_depth;
    if (filling && held >= DEPTH) begin
      full_items++;
      if (full_items >= FULL_DWELL) filling = 1'b0;
    end else if (!filling && held <= 4) begin
      filling    = 1'b1;
      full_items = 0;
      side_skew  = $urandom_range(10, 90);
    end
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 92)      op = OP_PUSH;
      else if (roll < 96) op = OP_POP;
      else if (roll < 99) op = OP_PEEK;
      else                op = OP_UNUSED;
      side = ($urandom_range(99) < side_skew);
    end else begin
      if (roll < 70)      op = OP_POP;
      else if (roll < 82) op = OP_PEEK;
      else if (roll < 96) op = OP_PUSH;
      else                op = OP_UNUSED;
      side = 1'($urandom_range(1));
    end
    offer_request(op, side, pick_value());
  endtask

  initial begin
    rst_ni            = 1'b0;
    rsp_hold          = 1'b0;
    pressure_req      = 1'b0;
    idle_mode         = IDLE_NONE;
    filling           = 1'b1;
    full_items        = 0;
    side_skew         = 50;
    req_if.valid      = 1'b0;
    req_if.op         = OP_PUSH;
    req_if.side       = 1'b0;
    req_if.push_value = '0;
    rsp_if.ready      = 1'b0;
    book              = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: underflow on both empty sides, the ignored op code, the
    // word extremes on both sides, peek then pop back to empty.
    offer_request(OP_POP,    1'b0, 32'h1234_5678);
    offer_request(OP_PEEK,   1'b0, 32'h0);
    offer_request(OP_POP,    1'b1, 32'hFFFF_FFFF);
    offer_request(OP_PEEK,   1'b1, 32'h8000_0000);
    offer_request(OP_UNUSED, 1'b0, 32'hDEAD_BEEF);
    offer_request(OP_PUSH,   1'b0, 32'h7FFF_FFFF);
    offer_request(OP_PUSH,   1'b0, 32'h8000_0000);
    offer_request(OP_PUSH,   1'b1, 32'hFFFF_FFFF);
    offer_request(OP_PUSH,   1'b1, 32'h0000_0000);
    offer_request(OP_PEEK,   1'b0, 32'h5555_5555);
    offer_request(OP_PEEK,   1'b1, 32'hAAAA_AAAA);
    offer_request(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
    offer_request(OP_POP,    1'b0, 32'h0);
    offer_request(OP_POP,    1'b1, 32'h0);
    offer_request(OP_POP,    1'b0, 32'h0);
    offer_request(OP_POP,    1'b1, 32'h0);
    offer_request(OP_POP,    1'b0, 32'h0);
    offer_request(OP_PEEK,   1'b1, 32'h0);
    offer_request(OP_PUSH,   1'b1, 32'hA5A5_A5A5);
    offer_request(OP_PUSH,   1'b0, 32'h5A5A_5A5A);
    offer_request(OP_POP,    1'b1, 32'h0);
    offer_request(OP_POP,    1'b0, 32'h0);

    // Random: walk the idling phases in order; the first phase also
    // carries the long receiver hold-off.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      idle_mode = idle_mode_e'(i / PHASE_ITEMS);
      if (i == 200) pressure_req = 1'b1;
      random_request();
    end
    req_if.valid <= 1'b0;

    // Drain: wait for every predicted response, then a few more cycles
    // to catch any stray item.
    while (book.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
